>>> src/nsr_pkg.sv
// Shared constants and types for the Newton-Raphson square root block.
// No dependencies; compiled first.
package nsr_pkg;

    localparam int OPND_W        = 32;   // signed operand width
    localparam int XW            = 32;   // running estimate width
    localparam int ROOT_W        = 24;   // result root width
    localparam int CNT_W         = 6;    // step counter width
    localparam int MAX_ITER      = 24;   // step limit
    localparam int FRAC_BITS_DEF = 16;   // default fraction bits

    localparam logic [XW-1:0] ROOT_MAX = XW'(32'h00FF_FFFF);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_UPD,
        S_FIN
    } state_t;

endpackage

>>> src/nsr_op_if.sv
// Operand request channel: valid/ready handshake with a signed operand.
// Depends on nsr_pkg for the operand width.
interface nsr_op_if;
    logic                             valid;
    logic                             ready;
    logic signed [nsr_pkg::OPND_W-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

>>> src/nsr_res_if.sv
// Result request channel: valid/ready handshake with root, error flag and step count.
// Depends on nsr_pkg for the field widths.
interface nsr_res_if;
    logic                        valid;
    logic                        ready;
    logic [nsr_pkg::ROOT_W-1:0]  root;
    logic                        negative_error;
    logic [nsr_pkg::CNT_W-1:0]   iterations_used;

    modport source (output valid, output root, output negative_error,
                    output iterations_used, input ready);
    modport sink   (input valid, input root, input negative_error,
                    input iterations_used, output ready);
endinterface

>>> src/newton_square_root.sv
// Newton-Raphson square root of a signed fixed-point operand.
// A negative or zero operand skips the iteration and goes straight to the result stage;
// otherwise up to 24 Newton steps run (Q16.16 by default), each one waiting on the result
// of the one shared radix-2 divider.
// One request at a time; the next can be taken the cycle after the result is queued.
// Reset (rst_n, async, active low) clears the sequencer and the result valid.
module newton_square_root #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    nsr_op_if.sink     op_chan,
    nsr_res_if.source  res_chan
);

    localparam int XW     = nsr_pkg::XW;
    localparam int N_W    = nsr_pkg::OPND_W - 1;
    localparam int DVD_W  = N_W + FRAC_BITS;
    localparam int CNT_W  = nsr_pkg::CNT_W;
    localparam int ROOT_W = nsr_pkg::ROOT_W;

    nsr_pkg::state_t state_reg, state_next;

    logic [N_W-1:0]    n_reg, n_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [XW-1:0]     best_reg, best_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;

    logic              out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  iter_reg, iter_next;

    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  quot;

    logic              accept;
    logic              trivial;
    logic [DVD_W:0]    sum;
    logic [DVD_W-1:0]  nx;
    logic [DVD_W-1:0]  x_ext;
    logic [CNT_W-1:0]  cnt_inc;
    logic              stop_back;
    logic              out_load;

    nsr_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({n_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (x_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign accept  = op_chan.valid && (state_reg == nsr_pkg::S_IDLE);
    assign trivial = op_chan.operand[nsr_pkg::OPND_W-1] || (op_chan.operand == '0);

    // x' = (x + n*2^F / x) / 2
    assign x_ext     = {{(DVD_W-XW){1'b0}}, x_reg};
    assign sum       = {1'b0, quot} + {1'b0, x_ext};
    assign nx        = sum[DVD_W:1];
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    // Converged, or no longer falling after the first step.
    assign stop_back = (nx == x_ext) || ((cnt_reg != '0) && (nx > x_ext));
    assign out_load  = !out_valid_reg || res_chan.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nsr_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = trivial ? nsr_pkg::S_FIN : nsr_pkg::S_START;
            end
            nsr_pkg::S_START:
                state_next = nsr_pkg::S_WAIT;
            nsr_pkg::S_WAIT:
            begin
                if (div_done)
                    state_next = nsr_pkg::S_UPD;
            end
            nsr_pkg::S_UPD:
            begin
                if (stop_back || (cnt_inc == CNT_W'(nsr_pkg::MAX_ITER)))
                    state_next = nsr_pkg::S_FIN;
                else
                    state_next = nsr_pkg::S_START;
            end
            nsr_pkg::S_FIN:
            begin
                if (out_load)
                    state_next = nsr_pkg::S_IDLE;
            end
            default:
                state_next = nsr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        n_next         = n_reg;
        x_next         = x_reg;
        best_next      = best_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        root_next      = root_reg;
        err_next       = err_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !res_chan.ready;
        div_start      = 1'b0;
        unique case (state_reg)
            nsr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    n_next    = op_chan.operand[N_W-1:0];
                    x_next    = XW'(1) << FRAC_BITS;
                    best_next = '0;
                    cnt_next  = '0;
                    neg_next  = op_chan.operand[nsr_pkg::OPND_W-1];
                end
            end
            nsr_pkg::S_START:
                div_start = 1'b1;
            nsr_pkg::S_WAIT:
                ;
            nsr_pkg::S_UPD:
            begin
                cnt_next = cnt_inc;
                if (stop_back)
                    best_next = x_reg;
                else
                begin
                    x_next    = nx[XW-1:0];
                    best_next = nx[XW-1:0];
                end
            end
            nsr_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    root_next      = (best_reg > nsr_pkg::ROOT_MAX) ?
                                     nsr_pkg::ROOT_MAX[ROOT_W-1:0] : best_reg[ROOT_W-1:0];
                    err_next       = neg_reg;
                    iter_next      = cnt_reg;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nsr_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        x_reg    <= x_next;
        best_reg <= best_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        root_reg <= root_next;
        err_reg  <= err_next;
        iter_reg <= iter_next;
    end

    assign op_chan.ready            = (state_reg == nsr_pkg::S_IDLE);
    assign res_chan.valid           = out_valid_reg;
    assign res_chan.root            = root_reg;
    assign res_chan.negative_error  = err_reg;
    assign res_chan.iterations_used = iter_reg;

endmodule

>>> src/nsr_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on nsr_pkg for the divisor width.
module nsr_div #(
    parameter int DVD_W = 47
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DVD_W-1:0]         dividend,
    input  logic [nsr_pkg::XW-1:0]   divisor,
    output logic                     done,
    output logic [DVD_W-1:0]         quotient
);

    localparam int XW = nsr_pkg::XW;
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [XW-1:0]    rem_reg, rem_next;
    logic [XW-1:0]    dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [XW:0]      rem_sh;
    logic [XW:0]      diff;
    logic             ge;

    // Bring down the next dividend bit and try the subtraction.
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};
    assign ge     = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[XW-1:0] : rem_sh[XW-1:0];
            // Quotient bits shift in behind the consumed dividend bits.
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> tb/newton_square_root_tb.sv
// Testbench for newton_square_root: random and directed Q16.16 operands, checked
// against an in-bench Newton iteration model. Depends on nsr_pkg and the channel interfaces.
`timescale 1ns / 100ps

module newton_square_root_tb;

    localparam int       FRAC       = nsr_pkg::FRAC_BITS_DEF;
    localparam int       OPND_W     = nsr_pkg::OPND_W;
    localparam int       ROOT_W     = nsr_pkg::ROOT_W;
    localparam int       CNT_W      = nsr_pkg::CNT_W;
    localparam int       HALF_CYCLE = 6;
    localparam int       RANDOM_OPS = 500;
    localparam int       CYCLE_CAP  = 3_000_000;
    localparam int       MAX_REPORT = 10;

    typedef struct {
        logic signed [OPND_W-1:0] operand;
        bit                       drain_first;  // hold until all roots are back
    } sqrt_req_t;

    typedef struct {
        logic [ROOT_W-1:0] root;
        logic              negative_error;
        logic [CNT_W-1:0]  iterations_used;
    } sqrt_res_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     op_valid   = 1'b0;
    logic signed [OPND_W-1:0] op_operand = '0;
    logic                     res_ready  = 1'b0;
    logic                     op_taken   = 1'b0;

    sqrt_req_t   operand_q[$];
    sqrt_res_t   pending_roots[$];
    int          total_requests = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          cycles         = 0;
    int          op_gap         = 0;
    int          res_stall      = 0;
    logic        calm;

    nsr_op_if  op_if();
    nsr_res_if res_if();

    assign op_if.valid   = op_valid;
    assign op_if.operand = op_operand;
    assign res_if.ready  = res_ready;

    // every fourth stretch of 40 results runs with no idling on either side
    assign calm = ((results_seen / 40) % 4) == 3;

    newton_square_root #(.FRAC_BITS(FRAC)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_chan  (op_if),
        .res_chan (res_if)
    );

    always #HALF_CYCLE clk = ~clk;

    function automatic sqrt_res_t newton_root_of(logic signed [OPND_W-1:0] opnd);
        sqrt_res_t   r;
        logic [63:0] scaled;
        logic [63:0] x;
        logic [63:0] best;
        logic [63:0] quot;
        logic [63:0] next_x;
        int          steps;
        bit          done;
        r.root            = '0;
        r.negative_error  = 1'b0;
        r.iterations_used = '0;
        if (opnd < 0)
        begin
            r.negative_error = 1'b1;
        end
        else if (opnd != 0)
        begin
            scaled = {32'd0, opnd} << FRAC;
            x      = 64'd1 << FRAC;
            best   = x;
            steps  = 0;
            done   = 1'b0;
            while (!done && steps < nsr_pkg::MAX_ITER)
            begin
                quot   = scaled / x;
                next_x = (x + quot) >> 1;
                steps++;
                // converged, or started climbing back after the first step
                if (next_x == x || (steps > 1 && next_x > x))
                begin
                    best = x;
                    done = 1'b1;
                end
                else
                begin
                    x    = next_x;
                    best = x;
                end
            end
            if (best > 64'(nsr_pkg::ROOT_MAX))
                best = 64'(nsr_pkg::ROOT_MAX);
            r.root            = best[ROOT_W-1:0];
            r.iterations_used = steps[CNT_W-1:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [OPND_W-1:0] random_operand();
        logic [31:0] v;
        int          m;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom();
            2, 3: v = $urandom_range(1, 65535);
            8:
            begin
                m = $urandom_range(1, 181);
                v = (m * m) << FRAC;
            end
            9: v = $urandom() | 32'h8000_0000;
            default:
            begin
                v = ({1'b0, 31'($urandom())}) >> $urandom_range(0, 30);
                if (v == 0)
                    v = 32'd1;
            end
        endcase
        return v;
    endfunction

    task automatic add_request(logic signed [OPND_W-1:0] opnd, bit drain);
        sqrt_req_t q;
        q.operand     = opnd;
        q.drain_first = drain;
        operand_q.push_back(q);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            op_valid <= 1'b0;
        end
        else if (op_valid && !op_taken)
        begin
            // hold the request until it is taken
        end
        else if (op_gap != 0)
        begin
            op_valid <= 1'b0;
            op_gap   <= op_gap - 1;
        end
        else if (operand_q.size() != 0 &&
                 !(operand_q[0].drain_first && pending_roots.size() != 0))
        begin
            op_valid   <= 1'b1;
            op_operand <= operand_q[0].operand;
            void'(operand_q.pop_front());
            op_gap     <= calm ? 0 : pick_gap();
        end
        else
        begin
            op_valid <= 1'b0;
        end
    end

    // result sink back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else if (res_stall != 0)
        begin
            res_ready <= 1'b0;
            res_stall <= res_stall - 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            res_ready <= 1'b0;
            res_stall <= pick_gap();
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin : result_check
        sqrt_res_t want;
        op_taken <= rst_n && op_if.valid && op_if.ready;
        if (rst_n && op_if.valid && op_if.ready)
            pending_roots.push_back(newton_root_of(op_if.operand));
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (pending_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("%0t: result with no request pending: root %h err %b iter %0d",
                             $realtime, res_if.root, res_if.negative_error,
                             res_if.iterations_used);
            end
            else
            begin
                want = pending_roots.pop_front();
                if (res_if.root !== want.root ||
                    res_if.negative_error !== want.negative_error ||
                    res_if.iterations_used !== want.iterations_used)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("%0t: root %h/%h err %b/%b iter %0d/%0d (expected/actual)",
                                 $realtime, want.root, res_if.root,
                                 want.negative_error, res_if.negative_error,
                                 want.iterations_used, res_if.iterations_used);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_CAP)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // edges of the range, sign handling, exact squares, odd bit patterns
        add_request(32'sh0000_0000, 1'b0);
        add_request(32'sh0000_0001, 1'b0);
        add_request(32'sh0000_0002, 1'b0);
        add_request(32'sh0000_0003, 1'b0);
        add_request(32'sh7FFF_FFFF, 1'b0);
        add_request(32'sh8000_0000, 1'b0);
        add_request(32'shFFFF_FFFF, 1'b0);
        add_request(32'sh0001_0000, 1'b0);
        add_request(32'sh0002_0000, 1'b0);
        add_request(32'sh0004_0000, 1'b0);
        add_request(32'sh0000_4000, 1'b0);
        add_request(32'sh0000_8000, 1'b0);
        add_request(32'sh0000_0100, 1'b0);
        add_request(32'sh4000_0000, 1'b0);
        add_request(32'sh7FFF_0000, 1'b0);
        add_request(32'sh1234_5678, 1'b0);
        add_request(32'sh5555_5555, 1'b0);
        add_request(32'sh2AAA_AAAA, 1'b0);
        add_request(32'shAAAA_AAAA, 1'b0);
        add_request(32'sh00FF_FFFF, 1'b0);
        for (int i = 0; i < RANDOM_OPS; i++)
            add_request(random_operand(), i == 0 || i == RANDOM_OPS / 2);
        total_requests = operand_q.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (results_seen < total_requests || pending_roots.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (mismatches == 0 && pending_roots.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
src/nsr_pkg.sv
src/nsr_op_if.sv
src/nsr_res_if.sv
src/nsr_div.sv
src/newton_square_root.sv
tb/newton_square_root_tb.sv
